FILE: src/lpr_pkg.sv
package lpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = 4;
  localparam int AGE_W     = 4;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 5;

  localparam logic [AGE_W-1:0] AGE_MAX      = AGE_W'(FRAMES - 1);
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(FRAMES);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 end_of_trace;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [CNT_W-1:0]     fault_total;
    logic [CNT_W-1:0]     hit_total;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, start scan
    logic scan;    // examine one frame
    logic update;  // commit replacement, load result
  } lpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } lpr_sts_t;

endpackage

FILE: src/lpr_ctrl.sv
module lpr_ctrl
  import lpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  lpr_sts_t sts,
  output lpr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/lpr_datapath.sv
module lpr_datapath
  import lpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lpr_cmd_t         cmd,
  output lpr_sts_t         sts,
  input  in_word_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_frames_in_use,
  output out_word_t        out_data
);

  logic [CFG_W-1:0]     frames_r;
  logic [PAGE_BITS-1:0] req_page_r;
  logic                 req_eot_r;
  logic [IDX_W-1:0]     last_idx_r;
  logic [IDX_W-1:0]     scan_idx_r;

  logic                 found_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic [AGE_W-1:0]     hit_age_r;
  logic                 empty_r;
  logic [IDX_W-1:0]     empty_idx_r;
  logic [IDX_W-1:0]     old_idx_r;
  logic [AGE_W-1:0]     old_age_r;
  logic [PAGE_BITS-1:0] old_page_r;

  logic [FRAMES-1:0]    slot_valid_r;
  logic [PAGE_BITS-1:0] slot_page_r [FRAMES];
  logic [AGE_W-1:0]     slot_age_r  [FRAMES];
  logic [CNT_W-1:0]     fault_r, hitc_r;
  out_word_t            out_r;

  logic [CFG_W-1:0]     n_active;
  logic                 cur_valid;
  logic [PAGE_BITS-1:0] cur_page;
  logic [AGE_W-1:0]     cur_age;
  logic [IDX_W-1:0]     sel;
  logic                 evict;
  logic [CNT_W-1:0]     fault_nxt, hitc_nxt;

  // frame count of zero acts as one, above FRAMES as FRAMES
  always_comb begin
    priority if (frames_r == '0)          n_active = CFG_W'(1);
    else if (frames_r > FRAMES_RESET)     n_active = FRAMES_RESET;
    else                                  n_active = frames_r;
  end

  assign cur_valid     = slot_valid_r[scan_idx_r];
  assign cur_page      = slot_page_r[scan_idx_r];
  assign cur_age       = slot_age_r[scan_idx_r];
  assign sts.scan_last = (scan_idx_r == last_idx_r);

  assign sel   = found_r ? hit_idx_r : (empty_r ? empty_idx_r : old_idx_r);
  assign evict = !found_r && !empty_r;

  assign fault_nxt = (!found_r && fault_r != '1) ? fault_r + 1'b1 : fault_r;
  assign hitc_nxt  = (found_r && hitc_r != '1) ? hitc_r + 1'b1 : hitc_r;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
    end else if (cfg_we) begin
      frames_r <= cfg_frames_in_use;
    end
  end

  // request capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_page_r <= in_data.page_number;
      req_eot_r  <= in_data.end_of_trace;
      last_idx_r <= IDX_W'(n_active - CFG_W'(1));
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      empty_r    <= 1'b0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (!found_r && cur_valid && cur_page == req_page_r) begin
        found_r   <= 1'b1;
        hit_idx_r <= scan_idx_r;
        hit_age_r <= cur_age;
      end
      if (!empty_r && !cur_valid) begin
        empty_r     <= 1'b1;
        empty_idx_r <= scan_idx_r;
      end
      // strictly older wins: ties keep the lower frame
      if (scan_idx_r == '0 || cur_age > old_age_r) begin
        old_idx_r  <= scan_idx_r;
        old_age_r  <= cur_age;
        old_page_r <= cur_page;
      end
    end
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      fault_r      <= '0;
      hitc_r       <= '0;
      for (int i = 0; i < FRAMES; i++) slot_age_r[i] <= '0;
    end else if (cmd.update) begin
      if (req_eot_r) begin
        slot_valid_r <= '0;
        fault_r      <= '0;
        hitc_r       <= '0;
        for (int i = 0; i < FRAMES; i++) slot_age_r[i] <= '0;
      end else begin
        fault_r <= fault_nxt;
        hitc_r  <= hitc_nxt;
        slot_valid_r[sel] <= 1'b1;
        for (int i = 0; i < FRAMES; i++) begin
          if (IDX_W'(i) == sel) begin
            slot_age_r[i] <= '0;
          end else if (IDX_W'(i) <= last_idx_r && slot_valid_r[i]
                       && (!found_r || slot_age_r[i] < hit_age_r)
                       && slot_age_r[i] != AGE_MAX) begin
            slot_age_r[i] <= slot_age_r[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !found_r) begin
      slot_page_r[sel] <= req_page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_r.hit           <= found_r;
      out_r.frame_index   <= sel;
      out_r.evicted_valid <= evict;
      out_r.evicted_page  <= evict ? old_page_r : '0;
      out_r.fault_total   <= fault_nxt;
      out_r.hit_total     <= hitc_nxt;
    end
  end

endmodule

FILE: src/lru_page_replacement_top.sv
// An accepted word is compared frame by frame against the active frames (1 to 16)
//   of the frame table, then committed once the result register is free.
// A new word is taken only after the previous word has been committed.
// Reset (synchronous, rst_n low): all frames empty, ages and both counts zero,
//   frames_in_use back to 16, no result pending.
module lru_page_replacement_top
  import lpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_frames_in_use
);

  lpr_cmd_t cmd;
  lpr_sts_t sts;

  // the frame-count register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: idle, scan one frame a cycle, commit when the result register is free
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // frame table, search registers, counters and the result word
  lpr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data           (in_data),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .out_data          (out_data)
  );

  // only one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.update}))
    else $error("controller issued more than one command");

  // an accepted word blocks the input until its result is committed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // a commit always presents a result
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("commit did not raise out_valid");

  // a commit never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

endmodule
